// File: hw/rtl/hcbd_pkg.sv
// Shared types, codes and character helpers for the chunked body decoder.
// No dependencies.
package hcbd_pkg;

	// Field widths, fixed by the stream formats
	localparam int unsigned OP_W     = 2;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned LEN_W    = 24;
	localparam int unsigned ERR_W    = 3;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned OUT_W    = 40;  // 8 + 24 + 3 packed, padded to bytes
	localparam int unsigned CFG_IDX_W = 1;

	// Defaults for the top-level parameters
	localparam int unsigned DEF_LINE_CAP    = 64;
	localparam int unsigned DEF_LENGTH_BITS = 24;

	// Configuration reset values
	localparam logic [LEN_W-1:0] MAX_BODY_RESET = 24'hFF_FFFF;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BODY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TRAILER  = 1'd1;

	// Request operations
	localparam logic [OP_W-1:0] OP_BYTE   = 2'd0;
	localparam logic [OP_W-1:0] OP_START  = 2'd1;
	localparam logic [OP_W-1:0] OP_END    = 2'd2;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// Result kinds
	localparam logic [KIND_W-1:0] K_FRAME = 2'd0;
	localparam logic [KIND_W-1:0] K_BYTE  = 2'd1;
	localparam logic [KIND_W-1:0] K_DONE  = 2'd2;
	localparam logic [KIND_W-1:0] K_ERROR = 2'd3;

	// Error codes
	localparam logic [ERR_W-1:0] E_NONE     = 3'd0;
	localparam logic [ERR_W-1:0] E_LONGLINE = 3'd1;
	localparam logic [ERR_W-1:0] E_NEGATIVE = 3'd2;
	localparam logic [ERR_W-1:0] E_LIMIT    = 3'd3;
	localparam logic [ERR_W-1:0] E_EARLY    = 3'd4;

	// Characters
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
	localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;

	typedef enum logic [2:0] {
		PH_SIZE_BLANK,
		PH_SIZE_BODY,
		PH_DATA,
		PH_DATA_LINE,
		PH_TRAILER,
		PH_IDLE
	} phase_t;

	function automatic logic is_hex(input logic [BYTE_W-1:0] c);
		return (c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]});
	endfunction

	// Only meaningful when is_hex is true
	function automatic logic [3:0] hex_value(input logic [BYTE_W-1:0] c);
		logic [3:0] v;
		if (c inside {[8'h30:8'h39]}) begin
			v = c[3:0];
		end else begin
			v = 4'(c[3:0] + 4'd9);  // 'a'/'A' low nibble is 1
		end
		return v;
	endfunction

	function automatic logic is_blank(input logic [BYTE_W-1:0] c);
		return (c inside {CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR});
	endfunction

endpackage

// File: hw/rtl/http_chunked_body_decoder.sv
// Chunked transfer decoder for HTTP/1.1 response bodies: top level.
// Depends on hcbd_pkg.
//
// Takes one request per cycle on the s_ stream (tuser = operation, tdata = byte) while the m_
// stream is not stalled, and answers every request with exactly one result on the m_ stream. A
// request goes into an input register, and the whole decode step (size line parsing, data
// pass-through, limit check against max_body_bytes) is one short combinational pass from there
// into the result register, so the block sustains one request per clock while the m_ stream is
// not stalled; the input and result registers let a new request in while a result still waits
// to be taken. Op 1 restarts the decoder at any time; after done or an error it answers framing
// results until the next restart. Configuration writes are taken on any cycle but should only
// be made while the block is idle.
module http_chunked_body_decoder #(
	parameter int unsigned LINE_CAP    = hcbd_pkg::DEF_LINE_CAP,    // 8..256
	parameter int unsigned LENGTH_BITS = hcbd_pkg::DEF_LENGTH_BITS  // 16..32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// requests
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [hcbd_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] stream_byte
	input  logic [hcbd_pkg::OP_W-1:0]     s_tuser,   // [1:0] op
	// results
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [hcbd_pkg::OUT_W-1:0]    m_tdata,   // [7:0] body_byte, [31:8] body_length,
	                                                 // [34:32] error_code, [39:35] zero
	output logic [hcbd_pkg::KIND_W-1:0]   m_tuser,   // [1:0] kind
	// configuration
	input  logic                          cfg_we,
	input  logic [hcbd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hcbd_pkg::LEN_W-1:0]    cfg_data
);

	// Line counter holds up to LINE_CAP-2
	localparam int unsigned LL_W   = $clog2(LINE_CAP);
	localparam int unsigned SIZE_W = LENGTH_BITS + 1;
	localparam int unsigned SUM_W  = ((SIZE_W > hcbd_pkg::LEN_W) ? SIZE_W : hcbd_pkg::LEN_W) + 1;
	localparam logic [LL_W-1:0]   LINE_LAST = LL_W'(LINE_CAP - 2);
	localparam logic [SIZE_W+3:0] SIZE_SAT  = (SIZE_W+4)'({SIZE_W{1'b1}});

	// configuration registers
	logic [hcbd_pkg::LEN_W-1:0] max_body_q;
	logic                       trailer_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_body_q <= hcbd_pkg::MAX_BODY_RESET;
			trailer_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				hcbd_pkg::CFG_MAX_BODY: max_body_q <= cfg_data;
				hcbd_pkg::CFG_TRAILER:  trailer_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	logic                        valid_s1;
	logic [hcbd_pkg::OP_W-1:0]   op_s1;
	logic [hcbd_pkg::BYTE_W-1:0] byte_s1;
	logic                        out_free;
	logic                        advance;

	assign out_free = !m_tvalid || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1   <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	// decoder state
	hcbd_pkg::phase_t           phase_q, phase_d;
	logic [LL_W-1:0]            line_q, line_d;
	logic [SIZE_W-1:0]          size_q, size_d;
	logic                       neg_q, neg_d;
	logic                       dend_q, dend_d;
	logic [hcbd_pkg::LEN_W-1:0] left_q, left_d;
	logic [hcbd_pkg::LEN_W-1:0] total_q, total_d;

	// result of this step
	logic [hcbd_pkg::KIND_W-1:0] kind_d;
	logic [hcbd_pkg::BYTE_W-1:0] bbyte_d;
	logic [hcbd_pkg::LEN_W-1:0]  blen_d;
	logic [hcbd_pkg::ERR_W-1:0]  err_d;

	// helpers
	logic              c_lf, c_hex, line_full, over_limit;
	logic [SIZE_W+3:0] shifted;
	logic [SIZE_W-1:0] size_add;
	logic [SUM_W-1:0]  sum;

	assign c_lf      = (byte_s1 == hcbd_pkg::CH_LF);
	assign c_hex     = hcbd_pkg::is_hex(byte_s1);
	assign line_full = (line_q >= LINE_LAST);

	// size * 16 + digit, saturating
	assign shifted  = {size_q, hcbd_pkg::hex_value(byte_s1)};
	assign size_add = (shifted > SIZE_SAT) ? SIZE_W'(SIZE_SAT) : shifted[SIZE_W-1:0];

	assign sum        = SUM_W'(total_q) + SUM_W'(size_q);
	assign over_limit = (sum > SUM_W'(max_body_q));

	always_comb begin
		phase_d = phase_q;
		line_d  = line_q;
		size_d  = size_q;
		neg_d   = neg_q;
		dend_d  = dend_q;
		left_d  = left_q;
		total_d = total_q;
		kind_d  = hcbd_pkg::K_FRAME;
		bbyte_d = '0;
		blen_d  = '0;
		err_d   = hcbd_pkg::E_NONE;

		if (op_s1 == hcbd_pkg::OP_START) begin
			phase_d = hcbd_pkg::PH_SIZE_BLANK;
			line_d  = '0;
			size_d  = '0;
			neg_d   = 1'b0;
			dend_d  = 1'b0;
			left_d  = '0;
			total_d = '0;
		end else if (op_s1 == hcbd_pkg::OP_UNUSED || phase_q == hcbd_pkg::PH_IDLE) begin
			// nothing to do
		end else if (op_s1 == hcbd_pkg::OP_END) begin
			phase_d = hcbd_pkg::PH_IDLE;
			if (phase_q == hcbd_pkg::PH_TRAILER) begin
				kind_d = hcbd_pkg::K_DONE;
				blen_d = total_q;
			end else begin
				kind_d = hcbd_pkg::K_ERROR;
				err_d  = hcbd_pkg::E_EARLY;
			end
		end else begin
			case (phase_q)
				hcbd_pkg::PH_DATA: begin
					left_d  = left_q - 1'b1;
					total_d = total_q + 1'b1;
					if (left_q == hcbd_pkg::LEN_W'(1)) begin
						phase_d = hcbd_pkg::PH_DATA_LINE;
					end
					kind_d  = hcbd_pkg::K_BYTE;
					bbyte_d = byte_s1;
				end
				hcbd_pkg::PH_DATA_LINE: begin
					if (c_lf) begin
						phase_d = hcbd_pkg::PH_SIZE_BLANK;
					end
				end
				hcbd_pkg::PH_TRAILER: begin
					if (c_lf || line_full) begin
						phase_d = hcbd_pkg::PH_IDLE;
						kind_d  = hcbd_pkg::K_DONE;
						blen_d  = total_q;
					end else begin
						line_d = line_q + 1'b1;
					end
				end
				default: begin
					// size line
					if (c_lf) begin
						line_d = '0;
						size_d = '0;
						dend_d = 1'b0;
						if (size_q == '0) begin
							neg_d = 1'b0;
							if (trailer_q) begin
								phase_d = hcbd_pkg::PH_TRAILER;
							end else begin
								phase_d = hcbd_pkg::PH_IDLE;
								kind_d  = hcbd_pkg::K_DONE;
								blen_d  = total_q;
							end
						end else if (neg_q) begin
							neg_d   = 1'b0;
							phase_d = hcbd_pkg::PH_IDLE;
							kind_d  = hcbd_pkg::K_ERROR;
							err_d   = hcbd_pkg::E_NEGATIVE;
						end else if (over_limit) begin
							phase_d = hcbd_pkg::PH_IDLE;
							kind_d  = hcbd_pkg::K_ERROR;
							err_d   = hcbd_pkg::E_LIMIT;
						end else begin
							// passed the limit check, so it fits the length width
							left_d  = size_q[hcbd_pkg::LEN_W-1:0];
							phase_d = hcbd_pkg::PH_DATA;
						end
					end else if (line_full) begin
						phase_d = hcbd_pkg::PH_IDLE;
						kind_d  = hcbd_pkg::K_ERROR;
						err_d   = hcbd_pkg::E_LONGLINE;
					end else begin
						line_d = line_q + 1'b1;
						if (phase_q == hcbd_pkg::PH_SIZE_BLANK) begin
							if (!hcbd_pkg::is_blank(byte_s1)) begin
								phase_d = hcbd_pkg::PH_SIZE_BODY;
								if (byte_s1 == hcbd_pkg::CH_MINUS) begin
									neg_d = 1'b1;
								end else if (c_hex) begin
									size_d = size_add;
								end else if (byte_s1 != hcbd_pkg::CH_PLUS) begin
									dend_d = 1'b1;
								end
							end
						end else if (!dend_q) begin
							if (c_hex) begin
								size_d = size_add;
							end else begin
								dend_d = 1'b1;
							end
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hcbd_pkg::PH_SIZE_BLANK;
			line_q  <= '0;
			size_q  <= '0;
			neg_q   <= 1'b0;
			dend_q  <= 1'b0;
			left_q  <= '0;
			total_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			line_q  <= line_d;
			size_q  <= size_d;
			neg_q   <= neg_d;
			dend_q  <= dend_d;
			left_q  <= left_d;
			total_q <= total_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tuser <= kind_d;
			m_tdata <= {5'b0, err_d, blen_d, bbyte_d};
		end
	end

endmodule
